>>> design/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Shared widths and limits for the group reverse stream block.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int VALUE_W   = 32;
  localparam int SIZE_W    = 5;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int CMP_W     = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

endpackage

>>> design/grs_ram.sv
// ----------------------------------------------------------------------------
// grs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/group_reverse_stream.sv
// ----------------------------------------------------------------------------
// group_reverse_stream
// Reverses a streamed list in groups of group_size values.
// ----------------------------------------------------------------------------
// Each input transfer writes its value into a 16-entry buffer RAM. When a
// group is full the buffered values are sent out in reverse order; when
// list_last arrives with a short group they are sent in arrival order. A
// group is emitted by a RAM read state, then one result per cycle from the
// registered read port while out_tready is high; no input is taken while a
// group drains. group_size of 0 or 1 passes each value through as a group
// of one, sizes above 16 act as 16. out_tuser marks the last result of each
// group, out_tlast the final result of the list.
module group_reverse_stream (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: group_size
  input  logic                          cfg_we,
  input  logic [grs_pkg::SIZE_W-1:0]    cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [grs_pkg::VALUE_W-1:0]   in_tdata,   // [31:0] value
  input  logic                          in_tlast,   // list_last
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [grs_pkg::VALUE_W-1:0]   out_tdata,  // [31:0] out_value
  output logic                          out_tuser,  // [0] run_last
  output logic                          out_tlast   // list_end
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam int IW = grs_pkg::IDX_W;
  localparam int CW = grs_pkg::CNT_W;
  localparam int KW = grs_pkg::CMP_W;

  logic [1:0]                  state_r, state_nxt;
  logic [grs_pkg::SIZE_W-1:0]  group_size_r;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               n_r, n_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic                        rev_r, rev_nxt;
  logic                        last_r, last_nxt;

  logic                        in_xfer, out_xfer;
  logic [KW-1:0]               size_ext, k_eff, n_in_ext;
  logic [CW-1:0]               n_in;
  logic                        do_rev, do_emit;
  logic [IW-1:0]               wr_idx;
  logic                        rd_en;
  logic [CW-1:0]               rd_pos, rd_cnt;
  logic [IW-1:0]               rd_idx;
  logic                        final_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_xfer   = out_tvalid & out_tready;

  // effective group size: at least one, at most the buffer depth
  always_comb begin
    size_ext = KW'(group_size_r);
    if (size_ext == '0) begin
      k_eff = KW'(1);
    end else if (size_ext > KW'(grs_pkg::MAX_GROUP)) begin
      k_eff = KW'(grs_pkg::MAX_GROUP);
    end else begin
      k_eff = size_ext;
    end
  end

  assign wr_idx   = (fill_r >= CW'(grs_pkg::MAX_GROUP)) ? '0 : fill_r[IW-1:0];
  assign n_in     = CW'({1'b0, wr_idx} + 1'b1);
  assign n_in_ext = KW'(n_in);
  assign do_rev   = (n_in_ext >= k_eff);
  assign do_emit  = do_rev | in_tlast;

  assign final_res = (CW'(pos_r + 1'b1) == n_r);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    pos_nxt   = pos_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    rd_en     = 1'b0;
    rd_pos    = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (do_emit) begin
            fill_nxt  = '0;
            n_nxt     = n_in;
            pos_nxt   = '0;
            rev_nxt   = do_rev;
            last_nxt  = in_tlast;
            state_nxt = ST_RD;
          end else begin
            fill_nxt = n_in;
          end
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (final_res) begin
            state_nxt = ST_IDLE;
          end else begin
            // fetch the next entry so it lands as this one is taken
            rd_en   = 1'b1;
            rd_pos  = CW'(pos_r + 1'b1);
            pos_nxt = rd_pos;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_cnt = rev_r ? CW'(n_r - 1'b1 - rd_pos) : rd_pos;
  assign rd_idx = rd_cnt[IW-1:0];

  grs_ram #(
    .WIDTH (grs_pkg::VALUE_W),
    .DEPTH (grs_pkg::MAX_GROUP)
  ) u_store (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wr_idx),
    .wdata (in_tdata),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (out_tdata)
  );

  assign out_tuser = final_res;
  assign out_tlast = final_res & last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      group_size_r <= grs_pkg::SIZE_RESET;
      fill_r       <= '0;
      n_r          <= '0;
      pos_r        <= '0;
      rev_r        <= 1'b0;
      last_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      pos_r   <= pos_nxt;
      rev_r   <= rev_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        group_size_r <= cfg_wdata;
      end
    end
  end

  // buffer never holds a full group between transfers
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(grs_pkg::MAX_GROUP))
    else $error("fill count reached buffer depth");

  // an emitting transfer always starts a drain with the buffer emptied
  a_emit_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && do_emit) |=> (state_r == ST_RD && fill_r == '0))
    else $error("emit did not start drain");

  // drain position stays inside the group being emitted
  a_pos_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (pos_r < n_r))
    else $error("drain position beyond group");

  // a held result keeps its data while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule
